@@ design/llvc_pkg.sv @@
package llvc_pkg;

    // Operation codes of the action field. Codes 6 and 7 carry no operation.
    typedef enum logic [2:0] {
        ACT_REPORT_START = 3'd0,
        ACT_REPORT_ITEM  = 3'd1,
        ACT_HEARTBEAT    = 3'd2,
        ACT_POLL         = 3'd3,
        ACT_LOOKUP       = 3'd4,
        ACT_SNAPSHOT     = 3'd5
    } t_action;

    // Sequencer states of the cache scan.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SNAP
    } t_state;

    // Configuration register indexes.
    typedef enum logic {
        CFG_TIMEOUT  = 1'b0,
        CFG_ERROR_ID = 1'b1
    } t_cfg_idx;

    // Commands from the sequencer to the liveness tracker.
    typedef struct packed {
        logic mark;        // a report start or a heartbeat marks a frame
        logic poll;        // a poll consumes the mark and checks the timeout
        logic timeout_we;  // write of the timeout register
    } t_live_cmd;

    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
    localparam logic [31:0] TIMEOUT_FLOOR = 32'd1000;
    localparam logic [7:0]  ERROR_ID_RESET = 8'hFF;
    localparam logic [7:0]  POS_SAT = 8'hFF;

endpackage

@@ design/llvc_entry_mem.sv @@
module llvc_entry_mem
    import llvc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  logic [7:0]         i_wid,
    input  logic [31:0]        i_wvalue,
    input  logic [IDX_W-1:0]   i_raddr,
    output logic [7:0]         o_rid,
    output logic [31:0]        o_rvalue
);

    logic [39:0] mem [DEPTH];
    logic [39:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wid, i_wvalue};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rid    = r_rdata[39:32];
    assign o_rvalue = r_rdata[31:0];

endmodule

@@ design/llvc_liveness.sv @@
module llvc_liveness
    import llvc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_live_cmd   i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_cfg_data,
    output logic        o_online,
    output logic [31:0] o_frames
);

    logic        r_pending;
    logic        r_online;
    logic [31:0] r_last_rx;
    logic [31:0] r_frames;
    logic [31:0] r_timeout;
    logic        n_pending;
    logic        n_online;
    logic [31:0] n_last_rx;
    logic [31:0] n_frames;
    logic [31:0] n_timeout;
    logic [31:0] silence;

    // Wrapping difference; a fresh frame always sets it to zero, which is below the floor.
    assign silence = i_now_ms - r_last_rx;

    always_comb begin
        n_pending = r_pending;
        n_online  = r_online;
        n_last_rx = r_last_rx;
        n_frames  = r_frames;
        n_timeout = r_timeout;
        if (i_cmd.mark) begin
            n_pending = 1'b1;
        end
        if (i_cmd.poll) begin
            if (r_pending) begin
                n_pending = 1'b0;
                n_last_rx = i_now_ms;
                n_frames  = r_frames + 32'd1;
                n_online  = 1'b1;
            end else if (r_online && (silence >= r_timeout)) begin
                n_online = 1'b0;
            end
        end
        if (i_cmd.timeout_we) begin
            n_timeout = (i_cfg_data < TIMEOUT_FLOOR) ? TIMEOUT_FLOOR : i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_online  <= 1'b0;
            r_last_rx <= '0;
            r_frames  <= '0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_pending <= n_pending;
            r_online  <= n_online;
            r_last_rx <= n_last_rx;
            r_frames  <= n_frames;
            r_timeout <= n_timeout;
        end
    end

    assign o_online = r_online;
    assign o_frames = r_frames;

endmodule

@@ design/link_liveness_value_cache.sv @@
// Link liveness and value cache for one remote sensor node.
//
// Requests enter on a command channel: a request is taken at a rising edge where
// start is high and busy is low. Its fields select one of six actions: report
// start, report item, heartbeat, poll, lookup and snapshot.
// Results leave on o_valid, one result per cycle with o_valid high for exactly
// that cycle; o_last marks the final result of a request. The receiver cannot
// stall, so the block never waits on it.
// Report start, report item, heartbeat, poll and unused codes update state at the
// accepting edge and give their status result in the next cycle; busy stays low,
// so such requests may follow each other in every cycle.
// A lookup walks the entries one per cycle through the single id comparator,
// reading the entry memory (one write port, one read port) one address ahead.
// Busy stays high while it visits the entries up to the first match, with the
// result in the cycle after the last of them. A snapshot emits one entry per cycle,
// min(entries_held, read_limit) results back to back, each registered from a busy cycle.
// Empty lookups and empty snapshots answer in the next cycle like a status request.
// The configuration port writes the timeout (raised to at least 1000) or the error
// id at any edge where i_cfg_we is high. Synchronous reset clears the counters,
// the liveness state and the entry count; the entry memory itself is not cleared.
module link_liveness_value_cache
    import llvc_pkg::*;
#(
    parameter int CACHE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_action,
    input  logic [7:0]         i_item_id,
    input  logic signed [31:0] i_item_value,
    input  logic [31:0]        i_now_ms,
    input  logic [7:0]         i_read_limit,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_hit,
    output logic [7:0]         o_out_id,
    output logic signed [31:0] o_out_value,
    output logic [4:0]         o_entries_held,
    output logic               o_node_online,
    output logic [31:0]        o_frames_seen,
    output logic               o_last
);

    localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   n_idx;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   n_n;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [7:0]         r_key;
    logic [7:0]         n_key;
    logic [7:0]         r_pos;
    logic [7:0]         n_pos;
    logic [7:0]         r_err_id;
    logic               r_valid;
    logic               n_valid;
    logic               r_hit;
    logic               n_hit;
    logic [7:0]         r_out_id;
    logic [7:0]         n_out_id;
    logic [31:0]        r_out_value;
    logic [31:0]        n_out_value;
    logic               r_last;
    logic               n_last;

    logic               accept;
    logic               mem_we;
    logic [CNT_W-1:0]   rd_next;
    logic [CNT_W-1:0]   raddr_wide;
    logic [CNT_W-1:0]   snap_n;
    logic [7:0]         rd_id;
    logic [31:0]        rd_value;
    logic               pos_ok;
    t_live_cmd          live_cmd;

    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign rd_next = CNT_W'(r_idx + 1'b1);
    assign pos_ok  = (r_pos < 8'(CACHE_DEPTH));
    // The count never exceeds the depth, so a smaller limit always fits the count width.
    assign snap_n  = (8'(r_count) <= i_read_limit) ? r_count : CNT_W'(i_read_limit);

    llvc_entry_mem #(
        .DEPTH (CACHE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (r_count[IDX_W-1:0]),
        .i_wid    (i_item_id),
        .i_wvalue (i_item_value),
        .i_raddr  (raddr_wide[IDX_W-1:0]),
        .o_rid    (rd_id),
        .o_rvalue (rd_value)
    );

    llvc_liveness u_live (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (live_cmd),
        .i_now_ms   (i_now_ms),
        .i_cfg_data (i_cfg_data),
        .o_online   (o_node_online),
        .o_frames   (o_frames_seen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // In idle the memory is kept reading entry zero, so a scan finds its first
    // entry ready in its first scan cycle; during a scan it reads one ahead.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_n         = r_n;
        n_key       = r_key;
        n_count     = r_count;
        n_pos       = r_pos;
        n_valid     = 1'b0;
        n_hit       = 1'b0;
        n_out_id    = '0;
        n_out_value = '0;
        n_last      = 1'b0;
        mem_we      = 1'b0;
        raddr_wide  = rd_next;
        live_cmd    = '0;
        live_cmd.timeout_we = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_TIMEOUT);

        unique case (r_state)
            ST_IDLE: begin
                raddr_wide = '0;
                if (accept) begin
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    case (t_action'(i_action))
                        ACT_REPORT_START: begin
                            live_cmd.mark = 1'b1;
                            n_count = '0;
                            n_pos   = '0;
                        end
                        ACT_REPORT_ITEM: begin
                            if (pos_ok && (i_item_id != r_err_id)
                                    && (r_count < CNT_W'(CACHE_DEPTH))) begin
                                mem_we  = 1'b1;
                                n_count = CNT_W'(r_count + 1'b1);
                            end
                            if (r_pos != POS_SAT) begin
                                n_pos = r_pos + 8'd1;
                            end
                        end
                        ACT_HEARTBEAT: begin
                            live_cmd.mark = 1'b1;
                        end
                        ACT_POLL: begin
                            live_cmd.poll = 1'b1;
                        end
                        ACT_LOOKUP: begin
                            if (r_count != '0) begin
                                n_valid = 1'b0;
                                n_last  = 1'b0;
                                n_key   = i_item_id;
                                n_idx   = '0;
                                n_state = ST_LOOKUP;
                            end
                        end
                        ACT_SNAPSHOT: begin
                            if (snap_n != '0) begin
                                n_valid = 1'b0;
                                n_last  = 1'b0;
                                n_n     = snap_n;
                                n_idx   = '0;
                                n_state = ST_SNAP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (rd_id == r_key) begin
                    n_valid     = 1'b1;
                    n_hit       = 1'b1;
                    n_out_id    = r_key;
                    n_out_value = rd_value;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end else if (rd_next == r_count) begin
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = rd_next;
                end
            end
            ST_SNAP: begin
                n_valid     = 1'b1;
                n_hit       = 1'b1;
                n_out_id    = rd_id;
                n_out_value = rd_value;
                if (rd_next == r_n) begin
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = rd_next;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pos    <= '0;
            r_err_id <= ERROR_ID_RESET;
            r_valid  <= 1'b0;
            r_hit    <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pos   <= n_pos;
            r_valid <= n_valid;
            r_hit   <= n_hit;
            r_last  <= n_last;
            if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_ERROR_ID)) begin
                r_err_id <= i_cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_n         <= n_n;
        r_key       <= n_key;
        r_out_id    <= n_out_id;
        r_out_value <= n_out_value;
    end

    assign o_valid        = r_valid;
    assign o_hit          = r_hit;
    assign o_out_id       = r_out_id;
    assign o_out_value    = $signed(r_out_value);
    assign o_last         = r_last;
    assign o_entries_held = 5'(r_count);

    // A snapshot result that is not the last one is always followed by another.
    a_snap_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("snapshot run broken before its last result");

    // A scan only runs over a non-empty cache and stays inside the filled entries.
    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> ((r_count != '0) && (r_idx < r_count)))
        else $error("scan index outside the cached entries");

    // A hit is only ever shown on a result.
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_valid)
        else $error("hit flag without a result");

    // The cache never changes while a scan is running.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_count))
        else $error("entry count changed during a scan");

endmodule

@@ dv/link_liveness_value_cache_tb.sv @@
module link_liveness_value_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import llvc_pkg::*;

    // The block is built with its default cache depth, and the shadow cache
    // below is sized to match.
    localparam int CACHE_DEPTH = 16;

    // The action field has two spare codes that must leave all state alone.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    // The longest correct stretch without any handshake is the largest sender gap
    // plus a full 16-entry lookup scan plus a short settle. This limit is many
    // times that.
    localparam int WATCHDOG_LIMIT = 1000;

    // One request as the sender presents it.
    typedef struct {
        logic [2:0]         act;
        logic [7:0]         id;
        logic signed [31:0] value;
        logic [31:0]        now;
        logic [7:0]         limit;
    } t_request;

    // One result as the block reports it.
    typedef struct {
        logic               hit;
        logic [7:0]         id;
        logic signed [31:0] value;
        logic [4:0]         held;
        logic               online;
        logic [31:0]        frames;
        logic               is_last;
    } t_answer;

    // A row of the directed plan. Rows whose outcome is obvious carry the
    // result typed in by hand; the other rows rely on the shadow cache.
    typedef struct {
        t_request rq;
        bit       typed;
        t_answer  ans;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_action;
    logic [7:0]         i_item_id;
    logic signed [31:0] i_item_value;
    logic [31:0]        i_now_ms;
    logic [7:0]         i_read_limit;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               o_valid;
    logic               o_hit;
    logic [7:0]         o_out_id;
    logic signed [31:0] o_out_value;
    logic [4:0]         o_entries_held;
    logic               o_node_online;
    logic [31:0]        o_frames_seen;
    logic               o_last;

    link_liveness_value_cache #(
        .CACHE_DEPTH(CACHE_DEPTH)
    ) uut (
        .*
    );

    // Shadow copy of everything the block remembers: the cached entries, the
    // report bookkeeping, the liveness tracker and both registers.
    logic [7:0]         shadow_ids  [CACHE_DEPTH];
    logic signed [31:0] shadow_vals [CACHE_DEPTH];
    int unsigned        shadow_held    = 0;
    int unsigned        shadow_pos     = 0;
    bit                 shadow_pending = 1'b0;
    logic [31:0]        shadow_rx_time = '0;
    logic [31:0]        shadow_frames  = '0;
    bit                 shadow_online  = 1'b0;
    logic [31:0]        shadow_timeout = TIMEOUT_RESET;
    logic [7:0]         shadow_err_id  = ERROR_ID_RESET;

    // Results of the request just accepted, then the queue of results that
    // the block still owes, oldest first.
    t_answer fresh_answers[$];
    t_answer answers_due[$];

    t_row        plan[$];
    t_answer     unused_ans;
    logic [7:0]  id_pool [8];
    bit          no_gaps       = 1'b0;
    int unsigned requests_sent = 0;
    int unsigned errors        = 0;
    int unsigned quiet_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_request mk_req(logic [2:0] act, logic [7:0] id,
                                        logic signed [31:0] value, logic [31:0] now,
                                        logic [7:0] limit);
        t_request r;
        r.act   = act;
        r.id    = id;
        r.value = value;
        r.now   = now;
        r.limit = limit;
        return r;
    endfunction

    function automatic t_answer mk_ans(logic hit, logic [7:0] id, logic signed [31:0] value,
                                       logic [4:0] held, logic online, logic [31:0] frames,
                                       logic is_last);
        t_answer a;
        a.hit     = hit;
        a.id      = id;
        a.value   = value;
        a.held    = held;
        a.online  = online;
        a.frames  = frames;
        a.is_last = is_last;
        return a;
    endfunction

    function automatic t_row row(t_request rq, bit typed, t_answer ans);
        t_row r;
        r.rq    = rq;
        r.typed = typed;
        r.ans   = ans;
        return r;
    endfunction

    // Every result carries the status of the node as it stands after the
    // request has been applied.
    function automatic t_answer shadow_answer(logic hit, logic [7:0] id,
                                              logic signed [31:0] value, logic is_last);
        return mk_ans(hit, id, value, 5'(shadow_held), shadow_online, shadow_frames, is_last);
    endfunction

    // Apply one accepted request to the shadow cache and collect the results
    // it must produce in fresh_answers.
    task automatic shadow_apply(input t_request rq);
        int unsigned n;
        bit          found;
        fresh_answers.delete();
        case (rq.act)
            ACT_REPORT_START: begin
                shadow_pending = 1'b1;
                shadow_held    = 0;
                shadow_pos     = 0;
            end
            ACT_REPORT_ITEM: begin
                // Items past the first CACHE_DEPTH of a report, error items and
                // items that find the cache full are dropped. The position
                // keeps counting and saturates.
                if (shadow_pos < CACHE_DEPTH && rq.id != shadow_err_id &&
                        shadow_held < CACHE_DEPTH) begin
                    shadow_ids[shadow_held]  = rq.id;
                    shadow_vals[shadow_held] = rq.value;
                    shadow_held++;
                end
                if (shadow_pos < POS_SAT)
                    shadow_pos++;
            end
            ACT_HEARTBEAT: begin
                shadow_pending = 1'b1;
            end
            ACT_POLL: begin
                if (shadow_pending) begin
                    shadow_pending = 1'b0;
                    shadow_rx_time = rq.now;
                    shadow_frames  = shadow_frames + 32'd1;
                    shadow_online  = 1'b1;
                end
                // The silence is measured modulo 2^32, so the tick may wrap.
                if (shadow_online && (rq.now - shadow_rx_time) >= shadow_timeout)
                    shadow_online = 1'b0;
            end
            ACT_LOOKUP: begin
                found = 1'b0;
                for (int i = 0; i < shadow_held && !found; i++) begin
                    if (shadow_ids[i] == rq.id) begin
                        fresh_answers.push_back(shadow_answer(1'b1, rq.id, shadow_vals[i], 1'b1));
                        found = 1'b1;
                    end
                end
                if (!found)
                    fresh_answers.push_back(shadow_answer(1'b0, '0, '0, 1'b1));
            end
            ACT_SNAPSHOT: begin
                n = (shadow_held < rq.limit) ? shadow_held : rq.limit;
                if (n > CACHE_DEPTH)
                    n = CACHE_DEPTH;
                if (n == 0)
                    fresh_answers.push_back(shadow_answer(1'b0, '0, '0, 1'b1));
                for (int i = 0; i < n; i++)
                    fresh_answers.push_back(shadow_answer(1'b1, shadow_ids[i], shadow_vals[i],
                                                          (i + 1 == n)));
            end
            default: ;
        endcase
        // Everything except lookups and snapshots answers with one status.
        if (rq.act != ACT_LOOKUP && rq.act != ACT_SNAPSHOT)
            fresh_answers.push_back(shadow_answer(1'b0, '0, '0, 1'b1));
    endtask

    // Present one request after a random gap and hold it until the block
    // takes it. Start is left high so that back-to-back requests need no
    // extra edge; it drops when the next request wants a gap or the sender drains.
    task automatic issue(input t_request rq, input bit typed, input t_answer typed_ans);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= rq.act;
        i_item_id    <= rq.id;
        i_item_value <= rq.value;
        i_now_ms     <= rq.now;
        i_read_limit <= rq.limit;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        // The request was taken at this edge.
        shadow_apply(rq);
        if (typed)
            answers_due.push_back(typed_ans);
        else
            foreach (fresh_answers[k])
                answers_due.push_back(fresh_answers[k]);
        requests_sent++;
    endtask

    task automatic send(input t_request rq);
        issue(rq, 1'b0, unused_ans);
    endtask

    // Stop sending and wait until the block has delivered every result it
    // owes, then let the settle time pass.
    task automatic drain(input int unsigned settle);
        start <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Registers are only written while the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_TIMEOUT)
            shadow_timeout = (data < TIMEOUT_FLOOR) ? TIMEOUT_FLOOR : data;
        else
            shadow_err_id = data[7:0];
    endtask

    // Ids come mostly from a small pool so that lookups hit and duplicates
    // occur; now and then the error id shows up.
    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 5) == 0)
            return shadow_err_id;
        return id_pool[3'($urandom_range(0, 7))];
    endfunction

    // Poll times cluster around the timeout boundary or shortly after the last
    // frame, with some arbitrary ticks thrown in.
    function automatic logic [31:0] poll_time();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return shadow_rx_time + shadow_timeout + 32'($urandom_range(0, 4)) - 32'd2;
            default: return shadow_rx_time + 32'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [7:0] snap_limit();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 18));
    endfunction

    // Results are sampled at the rising edge that ends their cycle, so the
    // values read here are the ones the block held during that cycle.
    always @(posedge i_clk) begin : result_monitor
        t_answer got;
        t_answer want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got = mk_ans(o_hit, o_out_id, o_out_value, o_entries_held, o_node_online,
                         o_frames_seen, o_last);
            if (answers_due.size() == 0) begin
                $error("result with nothing outstanding: hit %0b id %0d value %0d",
                       got.hit, got.id, got.value);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, got.hit);
                    errors++;
                end
                if (got.id !== want.id) begin
                    $error("out_id: expected %0d, got %0d", want.id, got.id);
                    errors++;
                end
                if (got.value !== want.value) begin
                    $error("out_value: expected %0d, got %0d", want.value, got.value);
                    errors++;
                end
                if (got.held !== want.held) begin
                    $error("entries_held: expected %0d, got %0d", want.held, got.held);
                    errors++;
                end
                if (got.online !== want.online) begin
                    $error("node_online: expected %0b, got %0b", want.online, got.online);
                    errors++;
                end
                if (got.frames !== want.frames) begin
                    $error("frames_seen: expected %0d, got %0d", want.frames, got.frames);
                    errors++;
                end
                if (got.is_last !== want.is_last) begin
                    $error("last: expected %0b, got %0b", want.is_last, got.is_last);
                    errors++;
                end
            end
        end
    end

    // The watchdog counts edges at which neither a request nor a result moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL link_liveness_value_cache");
            $finish;
        end
    end

    initial begin
        int unsigned phase_goal;
        int unsigned count;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= ACT_HEARTBEAT;
        i_item_id    <= '0;
        i_item_value <= '0;
        i_now_ms     <= '0;
        i_read_limit <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_TIMEOUT;
        i_cfg_data   <= '0;
        unused_ans    = mk_ans(0, 0, 0, 0, 0, 0, 0);

        // Directed plan, run with the reset values of the registers: a
        // timeout of 10000 ms and 0xFF as the error id.
        // An empty cache answers lookups and snapshots with an all-zero miss.
        plan.push_back(row(mk_req(ACT_LOOKUP, 8'h00, 0, 0, 0), 1,
                           mk_ans(0, 0, 0, 0, 0, 0, 1)));
        plan.push_back(row(mk_req(ACT_SNAPSHOT, 8'h00, 0, 0, 8'hFF), 1,
                           mk_ans(0, 0, 0, 0, 0, 0, 1)));
        // The spare codes change nothing, whatever the other fields hold.
        plan.push_back(row(mk_req(ACT_SPARE_6, 8'hFF, -1, 32'hFFFF_FFFF, 8'hFF), 1,
                           mk_ans(0, 0, 0, 0, 0, 0, 1)));
        plan.push_back(row(mk_req(ACT_SPARE_7, 8'h5A, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 8'h5A), 1,
                           mk_ans(0, 0, 0, 0, 0, 0, 1)));
        // A poll without a pending frame leaves the node offline.
        plan.push_back(row(mk_req(ACT_POLL, 0, 0, 32'd0, 0), 1,
                           mk_ans(0, 0, 0, 0, 0, 0, 1)));
        plan.push_back(row(mk_req(ACT_HEARTBEAT, 0, 0, 0, 0), 1,
                           mk_ans(0, 0, 0, 0, 0, 0, 1)));
        // The heartbeat is consumed at the top of the tick range.
        plan.push_back(row(mk_req(ACT_POLL, 0, 0, 32'hFFFF_FFFF, 0), 1,
                           mk_ans(0, 0, 0, 0, 1, 1, 1)));
        // The tick wraps: 9998 is 9999 ms later, one short of the timeout,
        // and 9999 reaches it.
        plan.push_back(row(mk_req(ACT_POLL, 0, 0, 32'd9998, 0), 1,
                           mk_ans(0, 0, 0, 0, 1, 1, 1)));
        plan.push_back(row(mk_req(ACT_POLL, 0, 0, 32'd9999, 0), 1,
                           mk_ans(0, 0, 0, 0, 0, 1, 1)));
        // An item without a report start is appended but marks no frame.
        plan.push_back(row(mk_req(ACT_REPORT_ITEM, 8'h03, 100, 0, 0), 1,
                           mk_ans(0, 0, 0, 1, 0, 1, 1)));
        plan.push_back(row(mk_req(ACT_POLL, 0, 0, 32'd20000, 0), 1,
                           mk_ans(0, 0, 0, 1, 0, 1, 1)));
        plan.push_back(row(mk_req(ACT_REPORT_START, 8'hFF, -1, 0, 8'hFF), 1,
                           mk_ans(0, 0, 0, 0, 0, 1, 1)));
        // A report with extreme values, an error item and a duplicate id.
        plan.push_back(row(mk_req(ACT_REPORT_ITEM, 8'h00, 32'sh8000_0000, 0, 0), 0, unused_ans));
        plan.push_back(row(mk_req(ACT_REPORT_ITEM, 8'hFF, 7, 0, 0), 0, unused_ans));
        plan.push_back(row(mk_req(ACT_REPORT_ITEM, 8'hA5, 32'sh7FFF_FFFF, 0, 0), 0, unused_ans));
        plan.push_back(row(mk_req(ACT_REPORT_ITEM, 8'h00, 5, 0, 0), 0, unused_ans));
        // The first of two entries with the same id wins.
        plan.push_back(row(mk_req(ACT_LOOKUP, 8'h00, 0, 0, 0), 1,
                           mk_ans(1, 8'h00, 32'sh8000_0000, 3, 0, 1, 1)));
        plan.push_back(row(mk_req(ACT_LOOKUP, 8'hA5, 0, 0, 0), 0, unused_ans));
        plan.push_back(row(mk_req(ACT_LOOKUP, 8'h5A, 0, 0, 0), 1,
                           mk_ans(0, 0, 0, 3, 0, 1, 1)));
        plan.push_back(row(mk_req(ACT_LOOKUP, 8'hFF, 0, 0, 0), 0, unused_ans));
        // A zero limit gives the empty snapshot even with entries cached.
        plan.push_back(row(mk_req(ACT_SNAPSHOT, 0, 0, 0, 8'h00), 1,
                           mk_ans(0, 0, 0, 3, 0, 1, 1)));
        plan.push_back(row(mk_req(ACT_SNAPSHOT, 0, 0, 0, 8'h02), 0, unused_ans));
        plan.push_back(row(mk_req(ACT_SNAPSHOT, 0, 0, 0, 8'hFF), 0, unused_ans));
        plan.push_back(row(mk_req(ACT_POLL, 0, 0, 32'h1234_5678, 0), 0, unused_ans));
        plan.push_back(row(mk_req(ACT_HEARTBEAT, 0, 0, 0, 0), 0, unused_ans));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k])
            issue(plan[k].rq, plan[k].typed, plan[k].ans);

        foreach (id_pool[k])
            id_pool[k] = 8'($urandom);

        // One long report, sent without gaps, pushes the report position
        // past the cache depth, so the late items must be dropped.
        no_gaps = 1'b1;
        send(mk_req(ACT_REPORT_START, 8'($urandom), $urandom, $urandom, 8'($urandom)));
        repeat (20)
            send(mk_req(ACT_REPORT_ITEM, pick_id(), $urandom, $urandom, 8'($urandom)));
        send(mk_req(ACT_SNAPSHOT, 8'($urandom), $urandom, $urandom, 8'hFF));
        send(mk_req(ACT_LOOKUP, pick_id(), $urandom, $urandom, 8'($urandom)));

        // Random phases, each under its own register setting: the floor raised from
        // zero, the largest timeout, the floor raised from 999, the floor itself, and random values.
        for (int phase = 0; phase < 5; phase++) begin
            drain(2);
            case (phase)
                0: begin
                    write_reg(CFG_TIMEOUT, 32'd0);
                    write_reg(CFG_ERROR_ID, 32'h0000_0000);
                end
                1: begin
                    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
                    write_reg(CFG_ERROR_ID, 32'h0000_0080);
                end
                2: begin
                    write_reg(CFG_TIMEOUT, 32'd999);
                    write_reg(CFG_ERROR_ID, 32'h0000_00FF);
                end
                3: begin
                    write_reg(CFG_TIMEOUT, TIMEOUT_FLOOR);
                    write_reg(CFG_ERROR_ID, 32'($urandom_range(0, 255)));
                end
                default: begin
                    write_reg(CFG_TIMEOUT, $urandom);
                    write_reg(CFG_ERROR_ID, $urandom);
                end
            endcase
            foreach (id_pool[k])
                id_pool[k] = 8'($urandom);

            phase_goal = requests_sent + 14;
            while (requests_sent < phase_goal) begin
                no_gaps = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        // A well-formed report, sometimes long enough to fill
                        // the cache, then questions about it.
                        count = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 20)
                                                            : $urandom_range(0, 8);
                        send(mk_req(ACT_REPORT_START, 8'($urandom), $urandom, $urandom,
                                    8'($urandom)));
                        repeat (count)
                            send(mk_req(ACT_REPORT_ITEM, pick_id(), $urandom, $urandom,
                                        8'($urandom)));
                        repeat ($urandom_range(1, 3))
                            send(mk_req(ACT_LOOKUP, pick_id(), $urandom, $urandom,
                                        8'($urandom)));
                        send(mk_req(ACT_SNAPSHOT, 8'($urandom), $urandom, $urandom,
                                    snap_limit()));
                    end
                    4, 5: begin
                        // Liveness traffic around the timeout boundary.
                        if ($urandom_range(0, 1) == 1)
                            send(mk_req(ACT_HEARTBEAT, 8'($urandom), $urandom, $urandom,
                                        8'($urandom)));
                        repeat ($urandom_range(1, 3))
                            send(mk_req(ACT_POLL, 8'($urandom), $urandom, poll_time(),
                                        8'($urandom)));
                    end
                    6, 7: begin
                        repeat ($urandom_range(1, 4)) begin
                            if ($urandom_range(0, 1) == 1)
                                send(mk_req(ACT_LOOKUP, ($urandom_range(0, 4) == 0) ?
                                            8'($urandom) : pick_id(),
                                            $urandom, $urandom, 8'($urandom)));
                            else
                                send(mk_req(ACT_SNAPSHOT, 8'($urandom), $urandom, $urandom,
                                            snap_limit()));
                        end
                    end
                    default: begin
                        // Noise: any code, any field values, including stray
                        // items and the spare codes.
                        repeat ($urandom_range(1, 4))
                            send(mk_req(3'($urandom_range(0, 7)), 8'($urandom), $urandom,
                                        $urandom, 8'($urandom)));
                    end
                endcase
                // Now and then the sender holds off until the block is idle.
                if ($urandom_range(0, 7) == 0)
                    drain(2);
            end
        end

        drain(20);
        if (errors == 0 && answers_due.size() == 0)
            $display("PASS link_liveness_value_cache");
        else
            $display("FAIL link_liveness_value_cache");
        $finish;
    end

endmodule
